>>> rtl/core/deadline_timer_table_top_macros.svh
// Assertion helpers for the timer table checks.
`ifndef DEADLINE_TIMER_TABLE_TOP_MACROS_SVH
`define DEADLINE_TIMER_TABLE_TOP_MACROS_SVH

// Checked property, disabled while reset is high.
`define DTT_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds across reset.
`define DTT_CHECK_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/dtt_pkg.sv
`timescale 1ns / 1ps
package dtt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int OWNER_BITS  = 8;
   localparam int TIME_BITS   = 48;
   localparam int ID_BITS     = 32;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_STOP    = 3'd1;
   localparam logic [2:0] KIND_RESTART = 3'd2;
   localparam logic [2:0] KIND_SERVICE = 3'd3;
   localparam logic [2:0] KIND_PURGE   = 3'd4;

   localparam logic [1:0] STS_DONE   = 2'd0;
   localparam logic [1:0] STS_MISS   = 2'd1;
   localparam logic [1:0] STS_REJECT = 2'd2;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [ID_BITS-1:0]    timer_ref;
      logic [OWNER_BITS-1:0] owner;
      logic [TIME_BITS-1:0]  due_time;
      logic [TIME_BITS-1:0]  period;
      logic [TIME_BITS-1:0]  current_time;
   } dtt_req_item_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [ID_BITS-1:0]    assigned_id;
      logic                  fired;
      logic [ID_BITS-1:0]    fired_id;
      logic [OWNER_BITS-1:0] fired_owner;
      logic [TIME_BITS-1:0]  earliest_due;
   } dtt_rsp_item_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [OWNER_BITS-1:0] owner;
      logic [TIME_BITS-1:0]  due;
      logic [TIME_BITS-1:0]  period;
   } dtt_entry_type;

   localparam int ENTRY_BITS = $bits(dtt_entry_type);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_START   = 8'b0000_0010,
      ST_SCAN    = 8'b0000_0100,
      ST_POST    = 8'b0000_1000,
      ST_MOVE_RD = 8'b0001_0000,
      ST_MOVE_WR = 8'b0010_0000,
      ST_REARM   = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } dtt_state_type;

endpackage

>>> rtl/core/dtt_ram.sv
`timescale 1ns / 1ps
module dtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/deadline_timer_table_top.sv
`timescale 1ns / 1ps
// Timer table: up to TABLE_DEPTH timers (id, owner, deadline, interval) kept in
// one synchronous RAM, plus a cached earliest deadline (0 = none).
// Request channel req_* carries one item per request kind: add, stop,
// restart-or-add, service at a time, purge an owner. Response channel rsp_*
// returns exactly one item per request, in order.
// One request is worked on at a time. Add and the quick-out cases go from
// ST_START straight to ST_DONE. Stop, restart, service and purge walk the
// table through the RAM read port, one entry per cycle; removing a one-shot
// or dropped entry then reads the last entry and writes it into the hole
// (ST_MOVE_RD, ST_MOVE_WR), and a periodic re-arm writes back in ST_REARM.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls and a second response is ready, the block
// holds in its final state until the register frees.
// Reset (synchronous) empties the table, clears the cache and the id counter;
// the RAM itself is not cleared since only entries below the count are read.
module deadline_timer_table_top
   import dtt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtt_req_item_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtt_rsp_item_type rsp_item
);

   dtt_state_type          state_ff, state_in;
   dtt_req_item_type       op_ff, op_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [TIME_BITS-1:0]   cache_ff, cache_in;
   logic [ID_BITS-1:0]     idctr_ff, idctr_in;
   logic [CNT_BITS-1:0]    iss_ff, iss_in;
   logic                   dvld_ff, dvld_in;
   logic [IDX_BITS-1:0]    didx_ff, didx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_BITS-1:0]    hit_idx_ff, hit_idx_in;
   dtt_entry_type          hit_ent_ff, hit_ent_in;
   logic [CNT_BITS-1:0]    wj_ff, wj_in;
   dtt_rsp_item_type       res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dtt_rsp_item_type       rsp_ff, rsp_in;

   // RAM port
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   dtt_entry_type          wr_ent;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [ENTRY_BITS-1:0]  rd_data;
   dtt_entry_type          rd_ent;

   // helpers
   logic [ID_BITS-1:0]     nid;
   logic                   can_append;
   dtt_entry_type          new_ent;
   logic                   issue;
   logic                   last_data;
   logic [TIME_BITS:0]     rearm_sum;
   logic [TIME_BITS-1:0]   rearm_due;
   logic [CNT_BITS-1:0]    count_dec;

   dtt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_ent = dtt_entry_type'(rd_data);

   // id counter skips zero on wrap
   assign nid        = (idctr_ff + 1'b1 == '0) ? ID_BITS'(1) : idctr_ff + 1'b1;
   assign can_append = (op_ff.due_time != '0) && (count_ff < CNT_BITS'(TABLE_DEPTH));
   assign new_ent    = '{id: nid, owner: op_ff.owner, due: op_ff.due_time,
                         period: op_ff.period};
   assign issue      = (iss_ff < count_ff);
   assign last_data  = dvld_ff && (CNT_BITS'(didx_ff) == count_ff - 1'b1);
   assign count_dec  = count_ff - 1'b1;

   // re-arm: saturating add, then no earlier than now
   assign rearm_sum  = {1'b0, hit_ent_ff.due} + {1'b0, hit_ent_ff.period};
   always_comb begin
      rearm_due = rearm_sum[TIME_BITS] ? '1 : rearm_sum[TIME_BITS-1:0];
      if (rearm_due < op_ff.current_time) begin
         rearm_due = op_ff.current_time;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      cache_in     = cache_ff;
      idctr_in     = idctr_ff;
      iss_in       = iss_ff;
      dvld_in      = 1'b0;
      didx_in      = didx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      wj_in        = wj_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_BITS-1:0];
      wr_ent       = new_ent;
      rd_addr      = iss_ff[IDX_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_item;
               state_in = ST_START;
            end
         end

         ST_START: begin
            res_in     = '0;
            res_in.status = STS_MISS;
            iss_in     = '0;
            hit_in     = 1'b0;
            wj_in      = '0;
            state_in   = ST_DONE;
            case (op_ff.req_type)
               KIND_ADD: begin
                  if (can_append) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     idctr_in = nid;
                     if (cache_ff == '0 || op_ff.due_time < cache_ff) begin
                        cache_in = op_ff.due_time;
                     end
                     res_in.status      = STS_DONE;
                     res_in.assigned_id = nid;
                  end else begin
                     res_in.status = STS_REJECT;
                  end
               end
               KIND_STOP, KIND_RESTART: begin
                  state_in = (op_ff.timer_ref == '0 || count_ff == '0) ? ST_POST : ST_SCAN;
               end
               KIND_SERVICE: begin
                  if (cache_ff != '0 && op_ff.current_time >= cache_ff) begin
                     cache_in = '0;
                     state_in = ST_SCAN;
                  end
               end
               KIND_PURGE: begin
                  if (count_ff != '0) begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  res_in.status = STS_REJECT;
               end
            endcase
         end

         ST_SCAN: begin
            if (issue) begin
               iss_in  = iss_ff + 1'b1;
               dvld_in = 1'b1;
               didx_in = iss_ff[IDX_BITS-1:0];
            end
            if (dvld_ff) begin
               case (op_ff.req_type)
                  KIND_STOP, KIND_RESTART: begin
                     if (!hit_ff && rd_ent.id == op_ff.timer_ref) begin
                        hit_in     = 1'b1;
                        hit_idx_in = didx_ff;
                     end
                  end
                  KIND_SERVICE: begin
                     if (!hit_ff && rd_ent.due <= op_ff.current_time) begin
                        hit_in     = 1'b1;
                        hit_idx_in = didx_ff;
                        hit_ent_in = rd_ent;
                     end else if (cache_ff == '0 || rd_ent.due < cache_ff) begin
                        cache_in = rd_ent.due;
                     end
                  end
                  KIND_PURGE: begin
                     // compaction: keepers move down to the write index
                     if (rd_ent.owner != op_ff.owner) begin
                        wr_en   = 1'b1;
                        wr_addr = wj_ff[IDX_BITS-1:0];
                        wr_ent  = rd_ent;
                        wj_in   = wj_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (last_data) begin
                  state_in = ST_POST;
               end
            end
         end

         ST_POST: begin
            state_in = ST_DONE;
            case (op_ff.req_type)
               KIND_STOP: begin
                  if (hit_ff) begin
                     res_in.status = STS_DONE;
                     state_in      = ST_MOVE_RD;
                  end
               end
               KIND_RESTART: begin
                  if (op_ff.due_time == '0) begin
                     res_in.status = STS_REJECT;
                     if (hit_ff) begin
                        state_in = ST_MOVE_RD;
                     end
                  end else if (hit_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = hit_idx_ff;
                     idctr_in = nid;
                     if (cache_ff == '0 || op_ff.due_time < cache_ff) begin
                        cache_in = op_ff.due_time;
                     end
                     res_in.status      = STS_DONE;
                     res_in.assigned_id = nid;
                  end else if (can_append) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     idctr_in = nid;
                     if (cache_ff == '0 || op_ff.due_time < cache_ff) begin
                        cache_in = op_ff.due_time;
                     end
                     res_in.status      = STS_DONE;
                     res_in.assigned_id = nid;
                  end else begin
                     res_in.status = STS_REJECT;
                  end
               end
               KIND_SERVICE: begin
                  if (hit_ff) begin
                     res_in.status      = STS_DONE;
                     res_in.fired       = 1'b1;
                     res_in.fired_id    = hit_ent_ff.id;
                     res_in.fired_owner = hit_ent_ff.owner;
                     state_in = (hit_ent_ff.period == '0) ? ST_MOVE_RD : ST_REARM;
                  end
               end
               KIND_PURGE: begin
                  count_in = wj_ff;
                  if (wj_ff != count_ff) begin
                     res_in.status = STS_DONE;
                  end
                  if (wj_ff == '0) begin
                     cache_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_MOVE_RD: begin
            // fetch the last entry to fill the hole
            rd_addr  = count_dec[IDX_BITS-1:0];
            state_in = ST_MOVE_WR;
         end

         ST_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = hit_idx_ff;
            wr_ent   = rd_ent;
            count_in = count_dec;
            if (count_dec == '0) begin
               cache_in = '0;
            end
            state_in = ST_DONE;
         end

         ST_REARM: begin
            wr_en      = 1'b1;
            wr_addr    = hit_idx_ff;
            wr_ent     = hit_ent_ff;
            wr_ent.due = rearm_due;
            if (cache_ff == '0 || rearm_due < cache_ff) begin
               cache_in = rearm_due;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = res_ff;
               rsp_in.earliest_due = cache_ff;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cache_ff     <= '0;
         idctr_ff     <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cache_ff     <= cache_in;
         idctr_ff     <= idctr_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      iss_ff     <= iss_in;
      didx_ff    <= didx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_ent_ff <= hit_ent_in;
      wj_ff      <= wj_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/core/dtt_checker.sv
`timescale 1ns / 1ps
`include "deadline_timer_table_top_macros.svh"
module dtt_checker
   import dtt_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dtt_req_item_type req_item,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dtt_rsp_item_type rsp_item
);

   `DTT_CHECK_RST(a_rsp_idle_after_reset, reset |=> !rsp_valid, "response after reset")
   `DTT_CHECK(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid, "stalled response dropped")
   `DTT_CHECK(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "second request taken")
   `DTT_CHECK(a_status_code, rsp_valid |-> rsp_item.status != 2'd3, "bad status code")
   `DTT_CHECK(a_fired_ok, rsp_valid && rsp_item.fired |-> rsp_item.status == STS_DONE && rsp_item.fired_id != '0, "fired without id")

endmodule

bind deadline_timer_table_top dtt_checker u_dtt_checker (.*);

>>> tb/dtt_checker.sv
`timescale 1ns / 1ps
module dtt_scoreboard
   import dtt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dtt_req_item_type req_item,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dtt_rsp_item_type rsp_item,
   output int               fail_count,
   output int               pending_count,
   output int               fire_count
);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam int EXP_DEPTH = 16;

   dtt_entry_type    tbl [TABLE_DEPTH];
   int               used;
   logic [TIME_BITS-1:0] early_due;
   logic [ID_BITS-1:0]   last_id;
   dtt_rsp_item_type     expected_mem [EXP_DEPTH];
   int                   exp_wr;
   int                   exp_rd;

   function automatic logic [ID_BITS-1:0] bump_id();
      last_id = last_id + 1;
      if (last_id == '0) last_id = 1;
      return last_id;
   endfunction

   function automatic int lookup(logic [ID_BITS-1:0] id);
      if (id == '0) return -1;
      for (int i = 0; i < used; i++) if (tbl[i].id == id) return i;
      return -1;
   endfunction

   function automatic void write_slot(int i, dtt_req_item_type r);
      tbl[i].id = bump_id();
      tbl[i].owner = r.owner;
      tbl[i].due = r.due_time;
      tbl[i].period = r.period;
      if (early_due == '0 || r.due_time < early_due) early_due = r.due_time;
   endfunction

   function automatic void remove_slot(int i);
      tbl[i] = tbl[used - 1];
      used--;
      if (used == 0) early_due = '0;
   endfunction

   function automatic logic [ID_BITS-1:0] append(dtt_req_item_type r);
      if (r.due_time == '0 || used >= TABLE_DEPTH) return '0;
      write_slot(used, r);
      used++;
      return tbl[used - 1].id;
   endfunction

   function automatic dtt_rsp_item_type timer_response(dtt_req_item_type r);
      dtt_rsp_item_type o;
      int s, k;
      logic [TIME_BITS-1:0] nxt;
      o = '0;
      o.status = STS_MISS;
      case (r.req_type)
         KIND_ADD: begin
            o.assigned_id = append(r);
            o.status = (o.assigned_id != '0) ? STS_DONE : STS_REJECT;
         end
         KIND_STOP: begin
            s = lookup(r.timer_ref);
            if (s >= 0) begin
               remove_slot(s);
               o.status = STS_DONE;
            end
         end
         KIND_RESTART: begin
            s = lookup(r.timer_ref);
            if (r.due_time == '0) begin
               if (s >= 0) remove_slot(s);
               o.status = STS_REJECT;
            end else if (s >= 0) begin
               write_slot(s, r);
               o.assigned_id = tbl[s].id;
               o.status = STS_DONE;
            end else begin
               o.assigned_id = append(r);
               o.status = (o.assigned_id != '0) ? STS_DONE : STS_REJECT;
            end
         end
         KIND_SERVICE: begin
            if (early_due != '0 && r.current_time >= early_due) begin
               early_due = '0;
               s = -1;
               for (int i = 0; i < used; i++) begin
                  if (s < 0 && tbl[i].due <= r.current_time) s = i;
                  else if (early_due == '0 || tbl[i].due < early_due)
                     early_due = tbl[i].due;
               end
               if (s >= 0) begin
                  o.fired = 1'b1;
                  o.fired_id = tbl[s].id;
                  o.fired_owner = tbl[s].owner;
                  o.status = STS_DONE;
                  if (tbl[s].period == '0) begin
                     tbl[s] = tbl[used - 1];
                     used--;
                  end else begin
                     nxt = (tbl[s].period > TIME_MAX - tbl[s].due) ? TIME_MAX
                           : tbl[s].due + tbl[s].period;
                     if (nxt < r.current_time) nxt = r.current_time;
                     tbl[s].due = nxt;
                     if (early_due == '0 || nxt < early_due) early_due = nxt;
                  end
               end
            end
         end
         KIND_PURGE: begin
            k = 0;
            for (int i = 0; i < used; i++) begin
               if (tbl[i].owner != r.owner) begin
                  tbl[k] = tbl[i];
                  k++;
               end
            end
            if (k != used) o.status = STS_DONE;
            used = k;
            if (used == 0) early_due = '0;
         end
         default: o.status = STS_REJECT;
      endcase
      o.earliest_due = early_due;
      return o;
   endfunction

   assign pending_count = exp_wr - exp_rd;

   always @(posedge clock) begin
      dtt_rsp_item_type want;
      if (reset) begin
         used = 0;
         early_due = '0;
         last_id = '0;
         fail_count = 0;
         fire_count = 0;
         exp_wr = 0;
         exp_rd = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_wr == exp_rd) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response %p", rsp_item);
            end else begin
               want = expected_mem[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_item.fired) fire_count++;
               if (rsp_item !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch at %0t: expected %p got %p", $time, want, rsp_item);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_mem[exp_wr % EXP_DEPTH] = timer_response(req_item);
            exp_wr++;
         end
      end
   end
endmodule

>>> tb/tb_deadline_timer_table_top.sv
`timescale 1ns / 1ps
module tb_deadline_timer_table_top;
   import dtt_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   dtt_req_item_type req_item;
   logic             rsp_valid;
   logic             rsp_stall;
   dtt_rsp_item_type rsp_item;
   int               fail_count, pending_count, fire_count;

   // ids handed out so far, used to aim stop/restart at live timers
   logic [ID_BITS-1:0] live_ids [32];
   int                 live_n = 0;
   int                 live_wp = 0;
   int                 sent;
   logic [TIME_BITS-1:0] clk_ticks;   // rising service time
   bit                 calm;          // no idling near the end

   deadline_timer_table_top u_dut (.*);

   dtt_scoreboard u_chk (
      .clock, .reset, .req_valid, .req_stall, .req_item,
      .rsp_valid, .rsp_stall, .rsp_item,
      .fail_count, .pending_count, .fire_count
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver stalls in random bursts
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // send one item; waits for accept, then maybe idles
   task automatic push(input dtt_req_item_type r);
      req_valid <= 1;
      req_item <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   function automatic dtt_req_item_type make(logic [2:0] k, logic [ID_BITS-1:0] id,
         logic [7:0] own, logic [47:0] due, logic [47:0] per, logic [47:0] now);
      dtt_req_item_type r;
      r.req_type = k; r.timer_ref = id; r.owner = own;
      r.due_time = due; r.period = per; r.current_time = now;
      return r;
   endfunction

   function automatic logic [ID_BITS-1:0] pick_ref();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom();
         default: return (live_n != 0) ? live_ids[$urandom_range(0, live_n - 1)]
                                       : $urandom_range(1, 40);
      endcase
   endfunction

   // random traffic, unknown kinds included: mostly near-future deadlines and rising service time
   function automatic dtt_req_item_type rand_req();
      logic [47:0] due, per;
      int          k;
      k = $urandom_range(0, 99);
      due = ($urandom_range(0, 19) == 0) ? rand48()
            : ($urandom_range(0, 29) == 0 ? 48'd0 : clk_ticks + $urandom_range(1, 500));
      per = ($urandom_range(0, 2) == 0) ? 48'd0
            : ($urandom_range(0, 9) == 0 ? rand48() : 48'($urandom_range(1, 300)));
      if (k < 30) return make(KIND_ADD, $urandom(), 8'($urandom_range(0, 3)), due, per,
                              rand48());
      if (k < 40) return make(KIND_STOP, pick_ref(), 8'($urandom()), rand48(), rand48(),
                              rand48());
      if (k < 52) return make(KIND_RESTART, pick_ref(), 8'($urandom_range(0, 3)), due, per,
                              rand48());
      if (k < 90) begin
         clk_ticks += $urandom_range(0, 120);
         return make(KIND_SERVICE, $urandom(), 8'($urandom()), rand48(), rand48(),
                     ($urandom_range(0, 24) == 0) ? rand48() : clk_ticks);
      end
      if (k < 97) return make(KIND_PURGE, $urandom(), 8'($urandom_range(0, 4)), rand48(),
                              rand48(), rand48());
      return make(3'($urandom_range(5, 7)), $urandom(), 8'($urandom()), rand48(), rand48(),
                  rand48());
   endfunction

   // watch assigned ids so stop/restart can name real timers
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall && rsp_item.assigned_id != '0) begin
         live_ids[live_wp] = rsp_item.assigned_id;
         live_wp = (live_wp + 1) % 32;
         if (live_n < 32) live_n++;
      end

   localparam logic [47:0] TMAX = '1;

   initial begin
      int wait_cycles;
      reset <= 1; req_valid <= 0; req_item <= '0; sent = 0; clk_ticks = 48'd1000; calm = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: service on empty table, rejects, extremes, periodic saturation
      push(make(KIND_SERVICE, '0, '0, '0, '0, TMAX));
      push(make(KIND_ADD, '0, 8'hff, '0, '0, '0));            // zero deadline rejected
      push(make(KIND_ADD, '1, 8'hff, TMAX, TMAX, TMAX));
      push(make(KIND_ADD, '0, 8'h00, 48'd1, '0, '0));
      push(make(KIND_ADD, '0, 8'h5a, 48'd100, 48'd50, '0));
      push(make(KIND_SERVICE, '0, '0, '0, '0, 48'd0));         // earlier than cache
      push(make(KIND_SERVICE, '0, '0, '0, '0, 48'd200));       // one-shot fires
      push(make(KIND_SERVICE, '0, '0, '0, '0, 48'd200));       // periodic, re-armed to now
      push(make(KIND_SERVICE, '0, '0, '0, '0, TMAX));          // saturating re-arm
      push(make(KIND_STOP, '0, '0, '0, '0, '0));               // id zero
      push(make(KIND_STOP, 32'd2, '0, '0, '0, '0));
      push(make(KIND_STOP, 32'd2, '0, '0, '0, '0));            // already gone
      push(make(KIND_RESTART, 32'd3, 8'h11, 48'd10, '0, '0));  // restart present
      push(make(KIND_RESTART, 32'd77, 8'h22, 48'd20, '0, '0)); // restart absent -> add
      push(make(KIND_RESTART, 32'd4, '0, '0, '0, '0));         // zero deadline stops
      push(make(KIND_PURGE, '0, 8'h22, '0, '0, '0));
      push(make(KIND_PURGE, '0, 8'h99, '0, '0, '0));           // nothing matches
      push(make(3'd7, '1, '1, TMAX, TMAX, TMAX));              // unknown kind
      for (int i = 0; i < 17; i++)                              // overfill the table
         push(make(KIND_ADD, '0, 8'(i & 1), 48'd5000 + i, '0, '0));
      push(make(KIND_PURGE, '0, 8'h01, '0, '0, '0));
      push(make(KIND_PURGE, '0, 8'h00, '0, '0, '0));           // leaves only the owner 8'hff timer

      for (int i = 0; i < 1300; i++) begin
         if (i == 1150) calm = 1;
         push(rand_req());
      end
      req_valid <= 0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      $display("Sent %0d timer requests; %0d service requests fired a timer.", sent, fire_count);
      if (fail_count == 0 && pending_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
